[src/cffh_pkg.sv]
package cffh_pkg;

    localparam logic [63:0] BASIS_64     = 64'hCBF29CE484222325;
    localparam logic [63:0] BASIS_32     = 64'h00000000811C9DC5;
    // prime = 2^40 + 0x1B3 (64-bit), 2^24 + 0x193 (32-bit)
    localparam int          PRIME64_SHIFT = 40;
    localparam logic [8:0]  PRIME64_LOW   = 9'h1B3;
    localparam int          PRIME32_SHIFT = 24;
    localparam logic [8:0]  PRIME32_LOW   = 9'h193;

    localparam logic [15:0] UPPER_A    = 16'h0041;
    localparam logic [15:0] UPPER_Z    = 16'h005A;
    localparam logic [15:0] CASE_DELTA = 16'h0020;

    localparam logic REG_HASH_IS_64 = 1'b0;
    localparam logic REG_WIDE_CHARS = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOW,
        S_HIGH,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load_char;
        logic absorb_low;
        logic absorb_high;
        logic emit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic last;
        logic empty;
        logic out_busy;
    } t_dp_stat;

    function automatic logic [15:0] fold_code(input logic [15:0] code);
        if (code >= UPPER_A && code <= UPPER_Z) begin
            return code + CASE_DELTA;
        end
        return code;
    endfunction

    function automatic logic [63:0] mode_basis(input logic is_64);
        return is_64 ? BASIS_64 : BASIS_32;
    endfunction

endpackage

[src/cffh_ctrl.sv]
module cffh_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic                i_wide,
    input  cffh_pkg::t_dp_stat  i_stat,
    output cffh_pkg::t_ctrl_cmd o_cmd
);
    import cffh_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_char = 1'b1;
                    n_state         = S_LOW;
                end
            end
            S_LOW: begin
                if (i_stat.empty) begin
                    n_state = i_stat.last ? S_EMIT : S_IDLE;
                end else begin
                    o_cmd.absorb_low = 1'b1;
                    if (i_wide) begin
                        n_state = S_HIGH;
                    end else begin
                        n_state = i_stat.last ? S_EMIT : S_IDLE;
                    end
                end
            end
            S_HIGH: begin
                o_cmd.absorb_high = 1'b1;
                n_state           = i_stat.last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[src/cffh_dp.sv]
module cffh_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cffh_pkg::t_ctrl_cmd i_cmd,
    output cffh_pkg::t_dp_stat  o_stat,
    input  logic                i_hash_is_64,
    input  logic                i_wide,
    input  logic                i_reload,
    input  logic [15:0]         i_char_code,
    input  logic                i_last,
    input  logic                i_empty,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [63:0]         o_m_tdata
);
    import cffh_pkg::*;

    logic [15:0] r_char;
    logic        r_last;
    logic        r_empty;
    logic [63:0] r_hash;
    logic [63:0] n_hash;
    logic        r_m_tvalid;
    logic [63:0] r_m_tdata;

    logic [7:0]  w_byte;
    logic [63:0] w_x;
    logic [63:0] w_p64;
    logic [31:0] w_p32;
    logic [15:0] w_fold;
    logic [15:0] w_fold_lo;

    // folding a zero-extended low byte never sets the upper byte
    assign w_fold_lo = fold_code({8'h00, i_char_code[7:0]});
    assign w_fold    = i_wide ? fold_code(i_char_code) : w_fold_lo;

    assign w_byte = i_cmd.absorb_high ? r_char[15:8] : r_char[7:0];
    assign w_x    = r_hash ^ {56'h0, w_byte};
    assign w_p64  = (w_x << PRIME64_SHIFT) + w_x * {55'h0, PRIME64_LOW};
    assign w_p32  = (w_x[31:0] << PRIME32_SHIFT) + w_x[31:0] * {23'h0, PRIME32_LOW};

    always_comb begin
        n_hash = r_hash;
        if (i_cmd.emit || i_reload) begin
            n_hash = mode_basis(i_hash_is_64);
        end else if (i_cmd.absorb_low || i_cmd.absorb_high) begin
            n_hash = i_hash_is_64 ? w_p64 : {32'h0, w_p32};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash     <= BASIS_64;
            r_m_tvalid <= 1'b0;
        end else begin
            r_hash <= n_hash;
            if (i_cmd.emit) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_char) begin
            r_char  <= w_fold;
            r_last  <= i_last;
            r_empty <= i_empty;
        end
        if (i_cmd.emit) begin
            r_m_tdata <= i_hash_is_64 ? r_hash : {32'h0, r_hash[31:0]};
        end
    end

    assign o_stat.last     = r_last;
    assign o_stat.empty    = r_empty;
    assign o_stat.out_busy = r_m_tvalid && !i_m_tready;
    assign o_m_tvalid      = r_m_tvalid;
    assign o_m_tdata       = r_m_tdata;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !(r_m_tvalid && !i_m_tready))
        else $error("emit while output register full");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_m_tvalid)
        else $error("emitted beat not shown");

    a_one_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.absorb_low && i_cmd.absorb_high) && !(i_cmd.emit && i_cmd.absorb_low))
        else $error("conflicting datapath commands");

    a_narrow_32: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_tvalid && $rose(r_m_tvalid) && !i_hash_is_64) |-> r_m_tdata[63:32] == 32'h0)
        else $error("upper half set in 32-bit result");

endmodule

[src/case_folding_fnv1a_hash.sv]
// An accepted beat is registered, then absorbed as its low byte and, for a wide
// character, its high byte (an empty beat absorbs nothing); a last beat then emits.
// Throughput: one hash byte step per cycle; a new character is accepted only after
// the previous one is absorbed, and emit waits while the output register is full.
// Reset: synchronous, active low; 64-bit mode, narrow characters, hash at 64-bit basis.
module case_folding_fnv1a_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] char_code
    input  logic        i_s_tlast,
    input  logic        i_s_tuser,   // [0] empty_string
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [63:0] hash_value
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cffh_pkg::*;

    logic      r_hash_is_64;
    logic      r_wide_chars;
    logic      r_reload;
    logic      w_wr;
    t_ctrl_cmd w_cmd;
    t_dp_stat  w_stat;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_WIDE_CHARS) ? {31'h0, r_wide_chars}
                                                 : {31'h0, r_hash_is_64};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_is_64 <= 1'b1;
            r_wide_chars <= 1'b0;
            r_reload     <= 1'b0;
        end else begin
            r_reload <= w_wr && (paddr[2] == REG_HASH_IS_64);
            if (w_wr && paddr[2] == REG_HASH_IS_64) begin
                r_hash_is_64 <= pwdata[0];
            end
            if (w_wr && paddr[2] == REG_WIDE_CHARS) begin
                r_wide_chars <= pwdata[0];
            end
        end
    end

    cffh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_wide     (r_wide_chars),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    cffh_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_hash_is_64 (r_hash_is_64),
        .i_wide       (r_wide_chars),
        .i_reload     (r_reload),
        .i_char_code  (i_s_tdata),
        .i_last       (i_s_tlast),
        .i_empty      (i_s_tuser),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata)
    );

endmodule

[sim/tb_case_folding_fnv1a_hash.sv]
`timescale 1ns / 100ps

module tb_case_folding_fnv1a_hash;
    import cffh_pkg::*;

    localparam int          HALF_PERIOD  = 10;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          SETTLE_WAIT  = 8;
    localparam int          RANDOM_ITEMS = 1925;
    localparam int          NUM_PHASES   = 8;
    localparam int          HOLD_AT_BEAT = 300;
    localparam int          HOLD_CYCLES  = 400;
    localparam logic [63:0] FNV64_BASIS  = 64'hCBF29CE484222325;
    localparam logic [63:0] FNV32_BASIS  = 64'h00000000811C9DC5;
    localparam logic [63:0] FNV64_PRIME  = 64'd1099511628211;
    localparam logic [31:0] FNV32_PRIME  = 32'd16777619;

    typedef struct packed {
        logic        is64;
        logic        wide;
        logic [15:0] code;
        logic        last;
        logic        empty;
        logic        known;
        logic [63:0] hash;
    } t_stim_row;

    localparam int NUM_ROWS = 26;
    localparam t_stim_row DIRECTED [NUM_ROWS] = '{
        '{1'b1, 1'b0, 16'h0000, 1'b1, 1'b1, 1'b1, FNV64_BASIS},
        '{1'b1, 1'b0, 16'h0041, 1'b1, 1'b0, 1'b0, 64'd0},
        '{1'b1, 1'b0, 16'h0061, 1'b1, 1'b0, 1'b0, 64'd0},
        '{1'b1, 1'b0, 16'h0040, 1'b1, 1'b0, 1'b0, 64'd0},
        '{1'b1, 1'b0, 16'h005A, 1'b1, 1'b0, 1'b0, 64'd0},
        '{1'b1, 1'b0, 16'h005B, 1'b1, 1'b0, 1'b0, 64'd0},
        '{1'b1, 1'b0, 16'hFF41, 1'b1, 1'b0, 1'b0, 64'd0},
        '{1'b1, 1'b0, 16'h0000, 1'b1, 1'b0, 1'b0, 64'd0},
        '{1'b1, 1'b0, 16'hFFFF, 1'b1, 1'b0, 1'b0, 64'd0},
        '{1'b1, 1'b0, 16'h0048, 1'b0, 1'b0, 1'b0, 64'd0},
        '{1'b1, 1'b0, 16'hABCD, 1'b0, 1'b1, 1'b0, 64'd0},
        '{1'b1, 1'b0, 16'h0049, 1'b0, 1'b0, 1'b0, 64'd0},
        '{1'b1, 1'b0, 16'h5555, 1'b1, 1'b1, 1'b0, 64'd0},
        '{1'b0, 1'b0, 16'h0000, 1'b1, 1'b1, 1'b1, FNV32_BASIS},
        '{1'b0, 1'b0, 16'h007A, 1'b1, 1'b0, 1'b0, 64'd0},
        '{1'b0, 1'b0, 16'h80FF, 1'b0, 1'b0, 1'b0, 64'd0},
        '{1'b0, 1'b1, 16'h0141, 1'b1, 1'b0, 1'b0, 64'd0},
        '{1'b0, 1'b1, 16'h0041, 1'b1, 1'b0, 1'b0, 64'd0},
        '{1'b0, 1'b1, 16'h5A5A, 1'b1, 1'b0, 1'b0, 64'd0},
        '{1'b1, 1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b1, FNV64_BASIS},
        '{1'b1, 1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b0, 64'd0},
        '{1'b1, 1'b1, 16'h7F5A, 1'b1, 1'b0, 1'b0, 64'd0},
        '{1'b1, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b0, 64'd0},
        '{1'b1, 1'b0, 16'h0062, 1'b1, 1'b0, 1'b0, 64'd0},
        '{1'b0, 1'b0, 16'h0058, 1'b0, 1'b0, 1'b0, 64'd0},
        '{1'b1, 1'b0, 16'h0000, 1'b1, 1'b1, 1'b1, FNV64_BASIS}
    };

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata  = '0;   // [15:0] char_code
    logic        i_s_tlast  = 1'b0;
    logic        i_s_tuser  = 1'b0; // [0] empty_string
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [63:0] o_m_tdata;         // [63:0] hash_value
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [2:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [63:0] expected_hashes [$];
    logic [63:0] running_hash;
    logic        mode_64;
    logic        mode_wide;
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          beats_accepted = 0;
    int          items_sent     = 0;
    bit          steady_sender  = 0;

    case_folding_fnv1a_hash u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s: got %h, want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic logic [63:0] basis_for(input logic is64);
        return is64 ? FNV64_BASIS : FNV32_BASIS;
    endfunction

    function automatic logic [15:0] to_lower_ascii(input logic [15:0] c);
        if (c >= 16'h0041 && c <= 16'h005A) begin
            return c + 16'h0020;
        end
        return c;
    endfunction

    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b,
                                             input logic is64);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        if (is64) begin
            return x * FNV64_PRIME;
        end
        return {32'd0, x[31:0] * FNV32_PRIME};
    endfunction

    task automatic fold_and_hash(input logic [15:0] code, input logic last,
                                 input logic empty, input logic known,
                                 input logic [63:0] known_hash);
        logic [15:0] c;
        if (!empty) begin
            if (mode_wide) begin
                c = to_lower_ascii(code);
                running_hash = fnv_step(running_hash, c[7:0], mode_64);
                running_hash = fnv_step(running_hash, c[15:8], mode_64);
            end else begin
                c = to_lower_ascii({8'd0, code[7:0]});
                running_hash = fnv_step(running_hash, c[7:0], mode_64);
            end
        end
        if (last) begin
            if (known) begin
                expected_hashes.push_back(known_hash);
            end else begin
                expected_hashes.push_back(mode_64 ? running_hash
                                                  : {32'd0, running_hash[31:0]});
            end
            running_hash = basis_for(mode_64);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_sender || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic send_beat(input logic [15:0] code, input logic last, input logic empty,
                             input logic known, input logic [63:0] known_hash);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= code;
        i_s_tlast  <= last;
        i_s_tuser  <= empty;
        do @(posedge i_clk); while (!o_s_tready);
        beats_accepted++;
        if (!empty || last) begin
            items_sent++;
        end
        fold_and_hash(code, last, empty, known, known_hash);
    endtask

    task automatic write_reg(input logic index, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Block must be quiet: results drained and any half-done character absorbed.
    task automatic set_mode(input logic is64, input logic wide, input bit rewrite);
        logic [31:0] junk;
        i_s_tvalid <= 1'b0;
        while (expected_hashes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
        junk = $urandom;
        if (is64 != mode_64 || rewrite) begin
            write_reg(REG_HASH_IS_64, {junk[31:1], is64});
            mode_64      = is64;
            running_hash = basis_for(is64);
        end
        if (wide != mode_wide) begin
            write_reg(REG_WIDE_CHARS, {junk[30:0], wide});
            mode_wide = wide;
        end
    endtask

    function automatic logic [15:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            return 16'($urandom_range(16'h0041, 16'h005A));
        end else if (r < 40) begin
            return 16'($urandom_range(16'h0061, 16'h007A));
        end else if (r < 55) begin
            return 16'($urandom_range(16'h003E, 16'h005D));
        end else if (r < 70) begin
            return 16'($urandom_range(16'h0020, 16'h007E));
        end
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    task automatic send_string();
        int          len;
        int          r;
        bit          end_on_empty;
        logic [15:0] junk;
        r = $urandom_range(0, 99);
        len = (r < 8) ? 0 : (r < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
        end_on_empty = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                junk = 16'($urandom);
                send_beat(junk, 1'b0, 1'b1, 1'b0, '0);
            end
            send_beat(pick_char(), (i == len - 1) && !end_on_empty, 1'b0, 1'b0, '0);
        end
        if (len == 0 || end_on_empty) begin
            junk = 16'($urandom);
            send_beat(junk, 1'b1, 1'b1, 1'b0, '0);
        end
    endtask

    task automatic random_phase(input int quota);
        int          stop_at;
        logic [15:0] junk;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 99) < 88) begin
                send_string();
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    junk = 16'($urandom);
                    send_beat(junk, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'b0, '0);
                end
            end
        end
        // sometimes leave a string open across the next mode write
        if ($urandom_range(0, 1) == 1) begin
            repeat ($urandom_range(1, 3)) send_beat(pick_char(), 1'b0, 1'b0, 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        logic [63:0] want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_hashes.size() == 0) begin
                report_mismatch("hash with nothing pending", o_m_tdata, '0);
            end else begin
                want = expected_hashes.pop_front();
                if (o_m_tdata !== want) begin
                    report_mismatch("hash_value", o_m_tdata, want);
                end
            end
        end
    end

    initial begin : result_ready
        bit held;
        int r;
        held = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && beats_accepted >= HOLD_AT_BEAT) begin
                held = 1;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    i_m_tready <= 1'b1;
                    repeat ($urandom_range(1, 20)) @(posedge i_clk);
                end else if (r < 93) begin
                    i_m_tready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end else begin
                    i_m_tready <= 1'b0;
                    repeat ($urandom_range(10, 60)) @(posedge i_clk);
                end
            end
        end
    end

    initial begin : stimulus
        t_stim_row row;
        mode_64      = 1'b1;
        mode_wide    = 1'b0;
        running_hash = FNV64_BASIS;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < NUM_ROWS; i++) begin
            row = DIRECTED[i];
            if (row.is64 != mode_64 || row.wide != mode_wide) begin
                set_mode(row.is64, row.wide, 1'b0);
            end
            send_beat(row.code, row.last, row.empty, row.known, row.hash);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < 4) begin
                set_mode(p[0] == 1'b0, p[1], 1'b0);
            end else begin
                set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
            end
            steady_sender = ($urandom_range(0, 3) == 0);
            random_phase(RANDOM_ITEMS / NUM_PHASES);
        end

        i_s_tvalid <= 1'b0;
        while (expected_hashes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
